>>> design/imusc_pkg.sv
`default_nettype none
package imusc_pkg;

  localparam int unsigned RAW_W    = 16;
  localparam int unsigned ACCEL_W  = 15;
  localparam int unsigned TEMP_W   = 12;
  localparam int unsigned RATE_W   = 22;
  localparam int unsigned RANGE_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // Product widths: 16-bit signed raw times the unit constant
  localparam int unsigned ACCEL_PROD_W = 26;
  localparam int unsigned RATE_PROD_W  = 36;

  localparam logic signed [ACCEL_PROD_W-1:0] ACCEL_MULT = 26'sd1000;
  localparam logic signed [RATE_PROD_W-1:0]  RATE_MULT  = 36'sd1000000;

  // Temperature: (raw + offset) / 34, truncated toward zero.
  // Magnitude is divided by multiplying with ceil(2^21 / 34).
  localparam logic signed [RAW_W:0] TEMP_OFFSET    = 17'sd12420;
  localparam logic [RAW_W-1:0]      TEMP_RECIP     = 16'd61681;
  localparam int unsigned           TEMP_RECIP_SH  = 21;
  localparam int unsigned           TEMP_PROD_W    = 2 * RAW_W;
  localparam int unsigned           TEMP_Q_W       = TEMP_PROD_W - TEMP_RECIP_SH;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_RANGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_RANGE  = 2'd1;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  function automatic logic [3:0] accel_shift(input logic [RANGE_W-1:0] range);
    logic [3:0] sh;
    case (range)
      2'd0: sh = 4'd14;
      2'd1: sh = 4'd13;
      2'd2: sh = 4'd12;
      2'd3: sh = 4'd11;
      default: sh = 4'd14;
    endcase
    return sh;
  endfunction

  function automatic logic [4:0] rate_shift(input logic [RANGE_W-1:0] range);
    logic [4:0] sh;
    case (range)
      2'd0: sh = 5'd17;
      2'd1: sh = 5'd16;
      2'd2: sh = 5'd15;
      2'd3: sh = 5'd14;
      default: sh = 5'd17;
    endcase
    return sh;
  endfunction

endpackage
`default_nettype wire

>>> design/imu_sample_unit_converter.sv
`default_nettype none
// IMU sample unit converter.
// Input channel (in_valid / in_stall) carries one raw burst: three accel words,
// one temperature word and three gyro words, all signed 16 bit. The result
// channel (out_valid / out_stall) carries the same burst in milli-g, tenths of
// a degree C and milli-degrees per second. A transaction completes on a rising
// edge with valid high and stall low.
// An input transaction passes through the stages in order: stage 1 forms the
// constant products and the temperature magnitude, stage 2 applies the range
// shifts and the reciprocal multiply, stage 3 is the output register.
// Throughput is one burst per cycle while out_stall is low; each stage has
// its own valid bit and advances when the stage after it is empty or moving.
// The cfg port writes accel_range (index 0) and gyro_range (index 1); write
// it only while no burst is in flight. Other indexes are ignored.
// Reset (rst_n low, synchronous) empties the pipeline and sets both ranges to
// zero (2 g and 250 dps).
// While out_stall is high with a result pending, the result holds, stages
// fill up behind it, and in_stall rises once all three stages are full.
module imu_sample_unit_converter (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_we,
  input  wire logic [imusc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [imusc_pkg::RANGE_W-1:0]          cfg_wdata,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [imusc_pkg::RAW_W-1:0]     in_raw_accel_x,
  input  wire logic signed [imusc_pkg::RAW_W-1:0]     in_raw_accel_y,
  input  wire logic signed [imusc_pkg::RAW_W-1:0]     in_raw_accel_z,
  input  wire logic signed [imusc_pkg::RAW_W-1:0]     in_raw_temperature,
  input  wire logic signed [imusc_pkg::RAW_W-1:0]     in_raw_gyro_x,
  input  wire logic signed [imusc_pkg::RAW_W-1:0]     in_raw_gyro_y,
  input  wire logic signed [imusc_pkg::RAW_W-1:0]     in_raw_gyro_z,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [imusc_pkg::ACCEL_W-1:0]        out_accel_x_mg,
  output logic signed [imusc_pkg::ACCEL_W-1:0]        out_accel_y_mg,
  output logic signed [imusc_pkg::ACCEL_W-1:0]        out_accel_z_mg,
  output logic signed [imusc_pkg::TEMP_W-1:0]         out_temperature_decideg,
  output logic signed [imusc_pkg::RATE_W-1:0]         out_rate_x_mdps,
  output logic signed [imusc_pkg::RATE_W-1:0]         out_rate_y_mdps,
  output logic signed [imusc_pkg::RATE_W-1:0]         out_rate_z_mdps
);

  logic [imusc_pkg::RANGE_W-1:0] accel_range_r;
  logic [imusc_pkg::RANGE_W-1:0] gyro_range_r;

  logic v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3;
  imusc_pkg::stage_en_t en;

  logic signed [imusc_pkg::RAW_W-1:0]        acc_raw [3];
  logic signed [imusc_pkg::RAW_W-1:0]        gyr_raw [3];
  logic signed [imusc_pkg::ACCEL_PROD_W-1:0] acc_prod_r [3];
  logic signed [imusc_pkg::RATE_PROD_W-1:0]  gyr_prod_r [3];
  logic signed [imusc_pkg::ACCEL_PROD_W-1:0] acc_sh [3];
  logic signed [imusc_pkg::RATE_PROD_W-1:0]  gyr_sh [3];
  logic [imusc_pkg::ACCEL_W-1:0]             acc_mid_r [3];
  logic [imusc_pkg::RATE_W-1:0]              gyr_mid_r [3];
  logic [imusc_pkg::ACCEL_W-1:0]             acc_out_r [3];
  logic [imusc_pkg::RATE_W-1:0]              gyr_out_r [3];
  logic [3:0]                                ashift;
  logic [4:0]                                gshift;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_range_r <= '0;
      gyro_range_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        imusc_pkg::CFG_ACCEL_RANGE: accel_range_r <= cfg_wdata;
        imusc_pkg::CFG_GYRO_RANGE:  gyro_range_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A stage moves when the one after it is empty or moving
  assign adv3     = !v3_r || !out_stall;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;
  assign en       = '{s1: adv1, s2: adv2, s3: adv3};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  assign acc_raw[0] = in_raw_accel_x;
  assign acc_raw[1] = in_raw_accel_y;
  assign acc_raw[2] = in_raw_accel_z;
  assign gyr_raw[0] = in_raw_gyro_x;
  assign gyr_raw[1] = in_raw_gyro_y;
  assign gyr_raw[2] = in_raw_gyro_z;

  assign ashift = imusc_pkg::accel_shift(accel_range_r);
  assign gshift = imusc_pkg::rate_shift(gyro_range_r);

  // Arithmetic shift of a signed product rounds toward minus infinity
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_sh[i] = acc_prod_r[i] >>> ashift;
      gyr_sh[i] = gyr_prod_r[i] >>> gshift;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (adv1) begin
        acc_prod_r[i] <= $signed({{(imusc_pkg::ACCEL_PROD_W - imusc_pkg::RAW_W)
                                   {acc_raw[i][imusc_pkg::RAW_W-1]}}, acc_raw[i]})
                         * imusc_pkg::ACCEL_MULT;
        gyr_prod_r[i] <= $signed({{(imusc_pkg::RATE_PROD_W - imusc_pkg::RAW_W)
                                   {gyr_raw[i][imusc_pkg::RAW_W-1]}}, gyr_raw[i]})
                         * imusc_pkg::RATE_MULT;
      end
      if (adv2) begin
        acc_mid_r[i] <= acc_sh[i][imusc_pkg::ACCEL_W-1:0];
        gyr_mid_r[i] <= gyr_sh[i][imusc_pkg::RATE_W-1:0];
      end
      if (adv3) begin
        acc_out_r[i] <= acc_mid_r[i];
        gyr_out_r[i] <= gyr_mid_r[i];
      end
    end
  end

  imusc_temp_conv u_temp (
    .clk                 (clk),
    .en                  (en),
    .raw_temperature     (in_raw_temperature),
    .temperature_decideg (out_temperature_decideg)
  );

  assign out_valid       = v3_r;
  assign out_accel_x_mg  = $signed(acc_out_r[0]);
  assign out_accel_y_mg  = $signed(acc_out_r[1]);
  assign out_accel_z_mg  = $signed(acc_out_r[2]);
  assign out_rate_x_mdps = $signed(gyr_out_r[0]);
  assign out_rate_y_mdps = $signed(gyr_out_r[1]);
  assign out_rate_z_mdps = $signed(gyr_out_r[2]);

endmodule
`default_nettype wire

>>> design/imusc_temp_conv.sv
`default_nettype none
module imusc_temp_conv (
  input  wire logic                                   clk,
  input  wire imusc_pkg::stage_en_t                   en,
  input  wire logic signed [imusc_pkg::RAW_W-1:0]     raw_temperature,
  output logic signed [imusc_pkg::TEMP_W-1:0]         temperature_decideg
);

  logic signed [imusc_pkg::RAW_W:0]     sum;
  logic [imusc_pkg::RAW_W:0]            mag_full;
  logic [imusc_pkg::RAW_W-1:0]          mag_nxt;
  logic [imusc_pkg::RAW_W-1:0]          mag_r;
  logic                                 neg_r;
  logic                                 neg2_r;
  logic [imusc_pkg::TEMP_PROD_W-1:0]    prod_nxt;
  logic [imusc_pkg::TEMP_PROD_W-1:0]    prod_r;
  logic [imusc_pkg::TEMP_Q_W-1:0]       quo;
  logic [imusc_pkg::TEMP_W-1:0]         temp_nxt;
  logic [imusc_pkg::TEMP_W-1:0]         temp_r;

  // Stage 1: offset, then split into sign and magnitude
  always_comb begin
    sum      = $signed({raw_temperature[imusc_pkg::RAW_W-1], raw_temperature})
               + imusc_pkg::TEMP_OFFSET;
    mag_full = sum[imusc_pkg::RAW_W] ? (17'd0 - 17'(sum)) : 17'(sum);
    mag_nxt  = mag_full[imusc_pkg::RAW_W-1:0];
  end

  // Stage 2: reciprocal multiply
  assign prod_nxt = {{imusc_pkg::RAW_W{1'b0}}, mag_r}
                    * {{imusc_pkg::RAW_W{1'b0}}, imusc_pkg::TEMP_RECIP};

  // Stage 3: drop fraction, restore sign (truncation toward zero)
  always_comb begin
    quo      = prod_r[imusc_pkg::TEMP_PROD_W-1:imusc_pkg::TEMP_RECIP_SH];
    temp_nxt = neg2_r ? (12'd0 - {1'b0, quo}) : {1'b0, quo};
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      mag_r <= mag_nxt;
      neg_r <= sum[imusc_pkg::RAW_W];
    end
    if (en.s2) begin
      prod_r <= prod_nxt;
      neg2_r <= neg_r;
    end
    if (en.s3) begin
      temp_r <= temp_nxt;
    end
  end

  assign temperature_decideg = $signed(temp_r);

endmodule
`default_nettype wire

>>> design/imusc_checker.sv
`default_nettype none
module imusc_checker (
  input wire logic                                   clk,
  input wire logic                                   rst_n,
  input wire logic                                   out_valid,
  input wire logic                                   out_stall,
  input wire logic signed [imusc_pkg::ACCEL_W-1:0]   out_accel_x_mg,
  input wire logic signed [imusc_pkg::TEMP_W-1:0]    out_temperature_decideg
);

  // Pending result stays offered while stalled
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped during stall");

  // Pipeline is empty the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_temperature_decideg >= -12'sd598)
                  && (out_temperature_decideg <= 12'sd1329))
    else $error("temperature out of range");

  a_accel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_accel_x_mg >= -15'sd16000) && (out_accel_x_mg <= 15'sd15999))
    else $error("accel x out of range");

endmodule

bind imu_sample_unit_converter imusc_checker u_imusc_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .out_valid               (out_valid),
  .out_stall               (out_stall),
  .out_accel_x_mg          (out_accel_x_mg),
  .out_temperature_decideg (out_temperature_decideg)
);
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int RESET_CYCLES     = 6;
  localparam int ACCEL_GAIN       = 1000;
  localparam int RATE_GAIN        = 1000000;
  localparam int TEMP_BIAS        = 12420;
  localparam int TEMP_STEP        = 34;
  localparam int ACCEL_BASE_SHIFT = 14;
  localparam int RATE_BASE_SHIFT  = 17;
  localparam int SETTLE_CYCLES    = 5;
  localparam int LONG_HOLD        = 300;
  localparam int HOLD_AFTER       = 600;
  localparam int PHASES           = 6;
  localparam int PHASE_BURSTS     = 315;
  localparam int LIMIT_NS         = 3000000;

  // indexes past the register list; writes there must leave both ranges alone
  localparam logic [imusc_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [imusc_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic signed [imusc_pkg::RAW_W-1:0] accel_x;
    logic signed [imusc_pkg::RAW_W-1:0] accel_y;
    logic signed [imusc_pkg::RAW_W-1:0] accel_z;
    logic signed [imusc_pkg::RAW_W-1:0] temperature;
    logic signed [imusc_pkg::RAW_W-1:0] gyro_x;
    logic signed [imusc_pkg::RAW_W-1:0] gyro_y;
    logic signed [imusc_pkg::RAW_W-1:0] gyro_z;
  } raw_burst_t;

  typedef struct packed {
    logic signed [imusc_pkg::ACCEL_W-1:0] accel_x_mg;
    logic signed [imusc_pkg::ACCEL_W-1:0] accel_y_mg;
    logic signed [imusc_pkg::ACCEL_W-1:0] accel_z_mg;
    logic signed [imusc_pkg::TEMP_W-1:0]  temperature_decideg;
    logic signed [imusc_pkg::RATE_W-1:0]  rate_x_mdps;
    logic signed [imusc_pkg::RATE_W-1:0]  rate_y_mdps;
    logic signed [imusc_pkg::RATE_W-1:0]  rate_z_mdps;
  } unit_result_t;

  class sample_scoreboard;
    logic [imusc_pkg::RANGE_W-1:0] accel_range;
    logic [imusc_pkg::RANGE_W-1:0] gyro_range;
    unit_result_t                  pending_units[$];
    int unsigned                   failures;

    function new();
      accel_range = '0;
      gyro_range  = '0;
      failures    = 0;
    endfunction

    function void write_range(logic [imusc_pkg::CFG_IDX_W-1:0] idx,
                              logic [imusc_pkg::RANGE_W-1:0] val);
      if (idx == imusc_pkg::CFG_ACCEL_RANGE) begin
        accel_range = val;
      end else if (idx == imusc_pkg::CFG_GYRO_RANGE) begin
        gyro_range = val;
      end
    endfunction

    // arithmetic shift of a signed product floors toward minus infinity
    function longint scale_floor(logic signed [imusc_pkg::RAW_W-1:0] raw, longint gain,
                                 int sh);
      return (longint'(raw) * gain) >>> sh;
    endfunction

    function unit_result_t convert_burst(raw_burst_t b);
      unit_result_t r;
      int ash;
      int gsh;
      int t;
      ash = ACCEL_BASE_SHIFT - int'(accel_range);
      gsh = RATE_BASE_SHIFT - int'(gyro_range);
      r.accel_x_mg = imusc_pkg::ACCEL_W'(scale_floor($signed(b.accel_x), ACCEL_GAIN, ash));
      r.accel_y_mg = imusc_pkg::ACCEL_W'(scale_floor($signed(b.accel_y), ACCEL_GAIN, ash));
      r.accel_z_mg = imusc_pkg::ACCEL_W'(scale_floor($signed(b.accel_z), ACCEL_GAIN, ash));
      // integer division truncates toward zero
      t = (int'($signed(b.temperature)) + TEMP_BIAS) / TEMP_STEP;
      r.temperature_decideg = imusc_pkg::TEMP_W'(t);
      r.rate_x_mdps = imusc_pkg::RATE_W'(scale_floor($signed(b.gyro_x), RATE_GAIN, gsh));
      r.rate_y_mdps = imusc_pkg::RATE_W'(scale_floor($signed(b.gyro_y), RATE_GAIN, gsh));
      r.rate_z_mdps = imusc_pkg::RATE_W'(scale_floor($signed(b.gyro_z), RATE_GAIN, gsh));
      return r;
    endfunction

    function void note_burst(raw_burst_t b);
      pending_units.push_back(convert_burst(b));
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(unit_result_t got);
      unit_result_t want;
      if (pending_units.size() == 0) begin
        $error("result transaction with no burst pending");
        failures++;
        return;
      end
      want = pending_units.pop_front();
      compare_field("accel_x_mg", $signed(want.accel_x_mg), $signed(got.accel_x_mg));
      compare_field("accel_y_mg", $signed(want.accel_y_mg), $signed(got.accel_y_mg));
      compare_field("accel_z_mg", $signed(want.accel_z_mg), $signed(got.accel_z_mg));
      compare_field("temperature_decideg", $signed(want.temperature_decideg),
                    $signed(got.temperature_decideg));
      compare_field("rate_x_mdps", $signed(want.rate_x_mdps), $signed(got.rate_x_mdps));
      compare_field("rate_y_mdps", $signed(want.rate_y_mdps), $signed(got.rate_y_mdps));
      compare_field("rate_z_mdps", $signed(want.rate_z_mdps), $signed(got.rate_z_mdps));
    endfunction
  endclass

  logic                                   clk = 1'b0;
  logic                                   rst_n;
  logic                                   cfg_we;
  logic [imusc_pkg::CFG_IDX_W-1:0]        cfg_index;
  logic [imusc_pkg::RANGE_W-1:0]          cfg_wdata;
  logic                                   in_valid;
  logic                                   in_stall;
  logic signed [imusc_pkg::RAW_W-1:0]     in_raw_accel_x;
  logic signed [imusc_pkg::RAW_W-1:0]     in_raw_accel_y;
  logic signed [imusc_pkg::RAW_W-1:0]     in_raw_accel_z;
  logic signed [imusc_pkg::RAW_W-1:0]     in_raw_temperature;
  logic signed [imusc_pkg::RAW_W-1:0]     in_raw_gyro_x;
  logic signed [imusc_pkg::RAW_W-1:0]     in_raw_gyro_y;
  logic signed [imusc_pkg::RAW_W-1:0]     in_raw_gyro_z;
  logic                                   out_valid;
  logic                                   out_stall;
  logic signed [imusc_pkg::ACCEL_W-1:0]   out_accel_x_mg;
  logic signed [imusc_pkg::ACCEL_W-1:0]   out_accel_y_mg;
  logic signed [imusc_pkg::ACCEL_W-1:0]   out_accel_z_mg;
  logic signed [imusc_pkg::TEMP_W-1:0]    out_temperature_decideg;
  logic signed [imusc_pkg::RATE_W-1:0]    out_rate_x_mdps;
  logic signed [imusc_pkg::RATE_W-1:0]    out_rate_y_mdps;
  logic signed [imusc_pkg::RATE_W-1:0]    out_rate_z_mdps;

  sample_scoreboard sb;
  raw_burst_t       seen_burst;
  unit_result_t     seen_result;
  int unsigned      accepted_bursts = 0;
  int               idle_odds = 4;
  bit               quiet = 1'b0;
  bit               valid_up = 1'b0;
  bit               hold_done = 1'b0;
  int               hold_left = 0;
  int               stall_left = 0;

  imu_sample_unit_converter dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_raw_accel_x          (in_raw_accel_x),
    .in_raw_accel_y          (in_raw_accel_y),
    .in_raw_accel_z          (in_raw_accel_z),
    .in_raw_temperature      (in_raw_temperature),
    .in_raw_gyro_x           (in_raw_gyro_x),
    .in_raw_gyro_y           (in_raw_gyro_y),
    .in_raw_gyro_z           (in_raw_gyro_z),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_accel_x_mg          (out_accel_x_mg),
    .out_accel_y_mg          (out_accel_y_mg),
    .out_accel_z_mg          (out_accel_z_mg),
    .out_temperature_decideg (out_temperature_decideg),
    .out_rate_x_mdps         (out_rate_x_mdps),
    .out_rate_y_mdps         (out_rate_y_mdps),
    .out_rate_z_mdps         (out_rate_z_mdps)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #(LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  // note accepted bursts and check accepted results on the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        seen_burst.accel_x     = in_raw_accel_x;
        seen_burst.accel_y     = in_raw_accel_y;
        seen_burst.accel_z     = in_raw_accel_z;
        seen_burst.temperature = in_raw_temperature;
        seen_burst.gyro_x      = in_raw_gyro_x;
        seen_burst.gyro_y      = in_raw_gyro_y;
        seen_burst.gyro_z      = in_raw_gyro_z;
        sb.note_burst(seen_burst);
        accepted_bursts++;
      end
      if (out_valid && !out_stall) begin
        seen_result.accel_x_mg          = out_accel_x_mg;
        seen_result.accel_y_mg          = out_accel_y_mg;
        seen_result.accel_z_mg          = out_accel_z_mg;
        seen_result.temperature_decideg = out_temperature_decideg;
        seen_result.rate_x_mdps         = out_rate_x_mdps;
        seen_result.rate_y_mdps         = out_rate_y_mdps;
        seen_result.rate_z_mdps         = out_rate_z_mdps;
        sb.check_result(seen_result);
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off to fill the pipeline
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (!hold_done && accepted_bursts >= HOLD_AFTER) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, idle_odds - 1) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_range(input logic [imusc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [imusc_pkg::RANGE_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_range(idx, val);
    @(posedge clk);
  endtask

  task automatic send_burst(input raw_burst_t b);
    in_valid           <= 1'b1;
    valid_up           = 1'b1;
    in_raw_accel_x     <= b.accel_x;
    in_raw_accel_y     <= b.accel_y;
    in_raw_accel_z     <= b.accel_z;
    in_raw_temperature <= b.temperature;
    in_raw_gyro_x      <= b.gyro_x;
    in_raw_gyro_y      <= b.gyro_y;
    in_raw_gyro_z      <= b.gyro_z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!quiet && $urandom_range(0, idle_odds - 1) == 0) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // drop valid, wait for every pending result, then let the pipeline settle
  task automatic drain_pipeline();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
    @(posedge clk);
    while (sb.pending_units.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic raw_burst_t pattern_burst(logic signed [imusc_pkg::RAW_W-1:0] a,
                                               logic signed [imusc_pkg::RAW_W-1:0] t,
                                               logic signed [imusc_pkg::RAW_W-1:0] g);
    raw_burst_t b;
    b.accel_x     = a;
    b.accel_y     = ~a;
    b.accel_z     = a;
    b.temperature = t;
    b.gyro_x      = g;
    b.gyro_y      = ~g;
    b.gyro_z      = g ^ 16'h5555;
    return b;
  endfunction

  function automatic logic [imusc_pkg::RAW_W-1:0] random_word(bit is_temp);
    logic [imusc_pkg::RAW_W-1:0] w;
    w = imusc_pkg::RAW_W'($urandom);
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: w = 16'h8000;
          1: w = 16'h7fff;
          2: w = 16'hffff;
          default: w = 16'h0000;
        endcase
      end
      1: w = imusc_pkg::RAW_W'($urandom_range(0, 64)) - 16'd32;
      // cluster around the temperature zero crossing to exercise truncation
      2: if (is_temp) w = imusc_pkg::RAW_W'(-TEMP_BIAS - int'($urandom_range(0, 80)) + 40);
      default: ;
    endcase
    return w;
  endfunction

  function automatic raw_burst_t random_burst();
    raw_burst_t b;
    b.accel_x     = random_word(1'b0);
    b.accel_y     = random_word(1'b0);
    b.accel_z     = random_word(1'b0);
    b.temperature = random_word(1'b1);
    b.gyro_x      = random_word(1'b0);
    b.gyro_y      = random_word(1'b0);
    b.gyro_z      = random_word(1'b0);
    return b;
  endfunction

  initial begin
    logic [imusc_pkg::RANGE_W-1:0] accel_set[4];
    logic [imusc_pkg::RANGE_W-1:0] gyro_set[4];
    accel_set = '{2'd1, 2'd2, 2'd3, 2'd3};
    gyro_set  = '{2'd1, 2'd2, 2'd3, 2'd0};
    sb = new();
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_wdata          <= '0;
    in_valid           <= 1'b0;
    in_raw_accel_x     <= '0;
    in_raw_accel_y     <= '0;
    in_raw_accel_z     <= '0;
    in_raw_temperature <= '0;
    in_raw_gyro_x      <= '0;
    in_raw_gyro_y      <= '0;
    in_raw_gyro_z      <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes and rounding corners at the reset ranges
    write_range(imusc_pkg::CFG_ACCEL_RANGE, 2'd0);
    write_range(imusc_pkg::CFG_GYRO_RANGE, 2'd0);
    send_burst(pattern_burst(16'sh7fff, 16'sh7fff, 16'sh7fff));
    send_burst(pattern_burst(16'sh8000, 16'sh8000, 16'sh8000));
    send_burst(pattern_burst(16'sh0000, 16'sh0000, 16'sh0000));
    send_burst(pattern_burst(-16'sd1, -16'sd1, -16'sd1));
    send_burst(pattern_burst(16'sd1, 16'sd1, 16'sd1));
    send_burst(pattern_burst(-16'sd1, -16'sd12420, 16'sd1));
    send_burst(pattern_burst(16'sd3, -16'sd12421, -16'sd3));
    send_burst(pattern_burst(-16'sd17, -16'sd12454, 16'sd17));
    send_burst(pattern_burst(16'sd17, -16'sd12455, -16'sd17));

    for (int s = 0; s < 4; s++) begin
      drain_pipeline();
      write_range(imusc_pkg::CFG_ACCEL_RANGE, accel_set[s]);
      write_range(imusc_pkg::CFG_GYRO_RANGE, gyro_set[s]);
      send_burst(pattern_burst(16'sh7fff, 16'sh7fff, 16'sh8000));
      send_burst(pattern_burst(16'sh8000, 16'sh8000, 16'sh7fff));
      send_burst(pattern_burst(-16'sd1, -16'sd12455, -16'sd1));
    end

    // writes past the register list must be ignored
    drain_pipeline();
    write_range(CFG_SPARE_LO, 2'd1);
    write_range(CFG_SPARE_HI, 2'd2);
    send_burst(pattern_burst(16'sh8000, 16'sh7fff, 16'sh8000));
    send_burst(pattern_burst(-16'sd1, -16'sd1, -16'sd1));

    for (int p = 0; p < PHASES; p++) begin
      drain_pipeline();
      case (p)
        0: begin
          write_range(imusc_pkg::CFG_ACCEL_RANGE, 2'd3);
          write_range(imusc_pkg::CFG_GYRO_RANGE, 2'd3);
        end
        1: begin
          write_range(imusc_pkg::CFG_ACCEL_RANGE, 2'd0);
          write_range(imusc_pkg::CFG_GYRO_RANGE, 2'd3);
        end
        2: begin
          write_range(imusc_pkg::CFG_ACCEL_RANGE, 2'd3);
          write_range(imusc_pkg::CFG_GYRO_RANGE, 2'd0);
        end
        3: begin
          write_range(imusc_pkg::CFG_ACCEL_RANGE, 2'd0);
          write_range(imusc_pkg::CFG_GYRO_RANGE, 2'd0);
        end
        default: begin
          write_range(imusc_pkg::CFG_ACCEL_RANGE,
                      imusc_pkg::RANGE_W'($urandom_range(0, 3)));
          write_range(imusc_pkg::CFG_GYRO_RANGE,
                      imusc_pkg::RANGE_W'($urandom_range(0, 3)));
        end
      endcase
      if ($urandom_range(0, 1) == 1) begin
        write_range($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                    imusc_pkg::RANGE_W'($urandom));
      end
      idle_odds = $urandom_range(2, 8);
      quiet = (p == PHASES - 1);
      repeat (PHASE_BURSTS) send_burst(random_burst());
    end

    drain_pipeline();
    if (sb.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> imu_sample_unit_converter.f
design/imusc_pkg.sv
design/imusc_temp_conv.sv
design/imu_sample_unit_converter.sv
design/imusc_checker.sv
tb/testbench.sv
